/* rtl/core/ltt_pkg.sv */
// Shared types and constants for the lambda term tokenizer.
// Used by ltt_scan, lambda_term_tokenizer and the testbench; depends on nothing else.
package ltt_pkg;

  // Width of the digit accumulator; numbers saturate at 2^NUMBER_BITS - 1
  localparam int NUMBER_BITS = 31;
  localparam int NUM_W       = 31;
  localparam int KIND_W      = 3;
  localparam int CHAR_W      = 8;

  // Token kinds
  localparam logic [KIND_W-1:0] KIND_NUM    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_LAMBDA = 3'd1;
  localparam logic [KIND_W-1:0] KIND_LETTER = 3'd2;
  localparam logic [KIND_W-1:0] KIND_OPEN   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLOSE  = 3'd4;

  // Character codes with a meaning of their own
  localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
  localparam logic [CHAR_W-1:0] CH_LAMBDA = 8'h4C;
  localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_OPEN   = 8'h28;
  localparam logic [CHAR_W-1:0] CH_CLOSE  = 8'h29;
  localparam logic [CHAR_W-1:0] CH_UC_A   = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UC_Z   = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LC_A   = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LC_Z   = 8'h7A;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              final_char;
  } char_t;

  typedef struct packed {
    logic [KIND_W-1:0] token_kind;
    logic [NUM_W-1:0]  number_value;
    logic [CHAR_W-1:0] letter_code;
    logic              last_of_run;
  } token_t;

  // Tokens caused by one character: up to two, in order
  typedef struct packed {
    logic [1:0] count;
    token_t     slot0;
    token_t     slot1;
  } scan_result_t;

endpackage

/* rtl/core/ltt_scan.sv */
// Character classifier and tokenizer state (digit accumulator and flags).
// Depends on ltt_pkg; produces the tokens for one request combinationally.
module ltt_scan import ltt_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         accept,
  input  char_t        item,
  output scan_result_t result
);

  localparam int WIDE_W = NUMBER_BITS + 4;

  logic [NUMBER_BITS-1:0] digit_accumulator;
  logic                   number_pending;
  logic                   abstraction_open;

  logic [NUMBER_BITS-1:0] digit_accumulator_next;
  logic                   number_pending_next;
  logic                   abstraction_open_next;

  logic [WIDE_W-1:0]      wide;
  logic [NUMBER_BITS-1:0] sat_value;
  logic                   is_digit;
  logic                   num_before;
  logic                   char_tok;
  logic                   num_final;
  token_t                 tok_num_old;
  token_t                 tok_num_new;
  token_t                 tok_char;

  // Multiply by ten as shift-add, then saturate
  always_comb begin
    wide = WIDE_W'({digit_accumulator, 3'b000}) + WIDE_W'({digit_accumulator, 1'b0})
         + WIDE_W'(item.char_code[3:0]);
    if (wide[WIDE_W-1:NUMBER_BITS] != '0) begin
      sat_value = '1;
    end else begin
      sat_value = wide[NUMBER_BITS-1:0];
    end
  end

  // Classify the character and build the candidate tokens
  always_comb begin
    is_digit   = (item.char_code >= CH_ZERO) && (item.char_code <= CH_NINE);
    num_before = !is_digit && number_pending;
    num_final  = is_digit && item.final_char;

    tok_num_old              = '0;
    tok_num_old.token_kind   = KIND_NUM;
    tok_num_old.number_value = NUM_W'(digit_accumulator);

    tok_num_new              = '0;
    tok_num_new.token_kind   = KIND_NUM;
    tok_num_new.number_value = NUM_W'(sat_value);

    tok_char = '0;
    char_tok = 1'b0;
    if (!is_digit) begin
      if (item.char_code == CH_LAMBDA) begin
        char_tok = 1'b0;
      end else if (item.char_code == CH_DOT) begin
        char_tok            = abstraction_open;
        tok_char.token_kind = KIND_LAMBDA;
      end else if (item.char_code inside {[CH_LC_A:CH_LC_Z], [CH_UC_A:CH_UC_Z]}) begin
        char_tok             = 1'b1;
        tok_char.token_kind  = KIND_LETTER;
        tok_char.letter_code = item.char_code;
      end else if (item.char_code == CH_OPEN) begin
        char_tok            = 1'b1;
        tok_char.token_kind = KIND_OPEN;
      end else if (item.char_code == CH_CLOSE) begin
        char_tok            = 1'b1;
        tok_char.token_kind = KIND_CLOSE;
      end
    end
  end

  // Pack tokens in order and flag the last one
  always_comb begin
    result       = '0;
    result.count = 2'(num_before) + 2'(char_tok) + 2'(num_final);
    if (num_before) begin
      result.slot0 = tok_num_old;
      result.slot1 = tok_char;
    end else if (char_tok) begin
      result.slot0 = tok_char;
    end else begin
      result.slot0 = tok_num_new;
    end
    if (result.count == 2'd2) begin
      result.slot1.last_of_run = 1'b1;
    end else begin
      result.slot0.last_of_run = 1'b1;
    end
  end

  // Next state for an accepted request
  always_comb begin
    digit_accumulator_next = digit_accumulator;
    number_pending_next    = number_pending;
    abstraction_open_next  = abstraction_open;
    if (item.final_char) begin
      digit_accumulator_next = '0;
      number_pending_next    = 1'b0;
      abstraction_open_next  = 1'b0;
    end else if (is_digit) begin
      digit_accumulator_next = sat_value;
      number_pending_next    = 1'b1;
    end else begin
      digit_accumulator_next = '0;
      number_pending_next    = 1'b0;
      if (item.char_code == CH_LAMBDA) begin
        abstraction_open_next = 1'b1;
      end else if (item.char_code == CH_DOT) begin
        abstraction_open_next = 1'b0;
      end
    end
  end

  // Advance state on accept
  always_ff @(posedge clk) begin
    if (rst) begin
      digit_accumulator <= '0;
      number_pending    <= 1'b0;
      abstraction_open  <= 1'b0;
    end else if (accept) begin
      digit_accumulator <= digit_accumulator_next;
      number_pending    <= number_pending_next;
      abstraction_open  <= abstraction_open_next;
    end
  end

endmodule

/* rtl/core/lambda_term_tokenizer.sv */
// Top level of the lambda term tokenizer: input channel, scanner, token queue.
// Depends on ltt_pkg and ltt_scan.
//
// Usage:
//   char channel  (char_valid, char_stall, char_item): one character per request,
//     final_char set on the last character of a term.
//   token channel (token_valid, token_stall, token): one token per request.
//   A character causes zero, one or two tokens; last_of_run marks the last one.
// A token is written into the queue register when its character is accepted and
//   leaves from there behind any older tokens, in order.
// Throughput: one character per cycle while char_stall is low; the single token port
//   passes one token per request, so a character causing two tokens needs two. The
//   four-entry token queue decouples the two sides: char_stall rises when more than
//   two tokens are waiting, so a stalled receiver backs up into the input and nothing
//   is lost.
// Reset: synchronous, active high; clears the accumulator, flags and queue.
//   No clearing pass is needed. The state also returns to its reset value
//   after each final character.
module lambda_term_tokenizer import ltt_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   char_valid,
  output logic   char_stall,
  input  char_t  char_item,
  output logic   token_valid,
  input  logic   token_stall,
  output token_t token
);

  localparam int DEPTH = 4;
  localparam int PTR_W = 2;

  token_t       queue [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  logic         char_accept;
  logic         token_pop;
  scan_result_t scan;

  assign char_stall  = (count > (PTR_W+1)'(2));
  assign char_accept = char_valid && !char_stall;
  assign token_valid = (count != '0);
  assign token_pop   = token_valid && !token_stall;
  assign token       = queue[rd_ptr];

  ltt_scan u_scan (
    .clk    (clk),
    .rst    (rst),
    .accept (char_accept),
    .item   (char_item),
    .result (scan)
  );

  // Write the tokens of an accepted request into the queue
  always_ff @(posedge clk) begin
    if (char_accept && (scan.count != 2'd0)) begin
      queue[wr_ptr] <= scan.slot0;
    end
    if (char_accept && (scan.count == 2'd2)) begin
      queue[wr_ptr + PTR_W'(1)] <= scan.slot1;
    end
  end

  // Advance pointers and the fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (char_accept) begin
        wr_ptr <= wr_ptr + PTR_W'(scan.count);
      end
      if (token_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count + (PTR_W+1)'(char_accept ? scan.count : 2'd0)
                     - (PTR_W+1)'(token_pop);
    end
  end

  // Queue never holds more than its depth
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= (PTR_W+1)'(DEPTH))
    else $error("token queue overflow");

  // A request that causes tokens shows a token on the next cycle
  a_token_follows: assert property (@(posedge clk) disable iff (rst)
    (char_accept && (scan.count != 2'd0)) |=> token_valid)
    else $error("accepted tokens not visible");

  // Reset empties the queue
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (count == '0))
    else $error("queue not empty after reset");

  // Only defined token kinds leave the block
  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    token_valid |-> (token.token_kind <= KIND_CLOSE))
    else $error("undefined token kind");

endmodule

/* verif/tb_lambda_term_tokenizer.sv */
// Testbench for lambda_term_tokenizer: streams lambda term characters, predicts tokens.
// Checks every token against an in-bench tokenizer model. Depends on ltt_pkg and the RTL.
module tb_lambda_term_tokenizer;
  import ltt_pkg::*;

  localparam longint unsigned SAT_MAX = (64'd1 << NUMBER_BITS) - 64'd1;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   char_valid = 1'b0;
  logic   char_stall;
  char_t  char_item = '0;
  logic   token_valid;
  logic   token_stall = 1'b0;
  token_t token;

  // Characters waiting to be sent, tokens predicted but not yet seen
  char_t  chars_to_send[$];
  token_t tokens_due[$];
  int     chars_accepted = 0;
  int     mismatches = 0;

  // Tokenizer state as the bench sees it
  logic [NUM_W-1:0] digit_run;
  bit               digit_run_live = 1'b0;
  bit               lambda_armed = 1'b0;

  wire calm = (chars_accepted >= 600) && (chars_accepted < 900);

  lambda_term_tokenizer i_dut (
    .clk         (clk),
    .rst         (rst),
    .char_valid  (char_valid),
    .char_stall  (char_stall),
    .char_item   (char_item),
    .token_valid (token_valid),
    .token_stall (token_stall),
    .token       (token)
  );

  always #5 clk = ~clk;

  initial digit_run = '0;

  function automatic token_t make_token(logic [KIND_W-1:0] kind, logic [NUM_W-1:0] num,
                                        logic [CHAR_W-1:0] letter);
    token_t t;
    t.token_kind   = kind;
    t.number_value = num;
    t.letter_code  = letter;
    t.last_of_run  = 1'b0;
    return t;
  endfunction

  // Predict the tokens of one accepted character and queue them
  task automatic tokenize_char(char_t c);
    token_t          found[$];
    longint unsigned acc;
    logic [CHAR_W-1:0] code;
    code = c.char_code;
    if (code >= CH_ZERO && code <= CH_NINE) begin
      acc = digit_run * 64'd10 + (code - CH_ZERO);
      if (acc > SAT_MAX) acc = SAT_MAX;
      digit_run = acc[NUM_W-1:0];
      digit_run_live = 1'b1;
    end else begin
      // a non-digit ends the digit run first
      if (digit_run_live) begin
        found.push_back(make_token(KIND_NUM, digit_run, '0));
        digit_run_live = 1'b0;
        digit_run = '0;
      end
      if (code == CH_LAMBDA) begin
        lambda_armed = 1'b1;
      end else if (code == CH_DOT) begin
        if (lambda_armed) begin
          lambda_armed = 1'b0;
          found.push_back(make_token(KIND_LAMBDA, '0, '0));
        end
      end else if ((code >= CH_UC_A && code <= CH_UC_Z) ||
                   (code >= CH_LC_A && code <= CH_LC_Z)) begin
        found.push_back(make_token(KIND_LETTER, '0, code));
      end else if (code == CH_OPEN) begin
        found.push_back(make_token(KIND_OPEN, '0, '0));
      end else if (code == CH_CLOSE) begin
        found.push_back(make_token(KIND_CLOSE, '0, '0));
      end
    end
    // flush the number and drop all state at the end of a term
    if (c.final_char) begin
      if (digit_run_live) found.push_back(make_token(KIND_NUM, digit_run, '0));
      digit_run = '0;
      digit_run_live = 1'b0;
      lambda_armed = 1'b0;
    end
    if (found.size() > 0) found[found.size()-1].last_of_run = 1'b1;
    foreach (found[i]) tokens_due.push_back(found[i]);
  endtask

  task automatic push_char(logic [CHAR_W-1:0] code, bit fin);
    char_t c;
    c.char_code  = code;
    c.final_char = fin;
    chars_to_send.push_back(c);
  endtask

  task automatic queue_text(string s, bit ends_term);
    for (int i = 0; i < s.len(); i++)
      push_char(s[i], ends_term && (i == s.len() - 1));
  endtask

  // Queue one random term; most are well formed, a few are pure noise
  task automatic queue_term();
    char_t term[$];
    char_t c;
    int    len;
    int    pick;
    int    run;
    bit    noisy;
    noisy = ($urandom_range(9) == 0);
    len = $urandom_range(24, 1);
    c.final_char = 1'b0;
    while (term.size() < len) begin
      pick = $urandom_range(99);
      if (noisy || pick < 8) begin
        c.char_code = CHAR_W'($urandom_range(255));
        term.push_back(c);
      end else if (pick < 30) begin
        // mostly short digit runs, sometimes long enough to saturate
        run = ($urandom_range(9) == 0) ? $urandom_range(13, 10) : $urandom_range(4, 1);
        repeat (run) begin
          c.char_code = CH_ZERO + CHAR_W'($urandom_range(9));
          term.push_back(c);
        end
      end else begin
        if (pick < 42)      c.char_code = CH_LAMBDA;
        else if (pick < 54) c.char_code = CH_DOT;
        else if (pick < 78) c.char_code = $urandom_range(1) ?
                                          CH_UC_A + CHAR_W'($urandom_range(25)) :
                                          CH_LC_A + CHAR_W'($urandom_range(25));
        else if (pick < 87) c.char_code = CH_OPEN;
        else if (pick < 96) c.char_code = CH_CLOSE;
        else                c.char_code = 8'h20;
        term.push_back(c);
      end
    end
    term[term.size()-1].final_char = 1'b1;
    foreach (term[i]) chars_to_send.push_back(term[i]);
  endtask

  // Character driver: hold a stalled request, otherwise send the next or idle
  always @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else begin
      if (char_valid && !char_stall) begin
        tokenize_char(char_item);
        chars_accepted <= chars_accepted + 1;
      end
      if (!char_valid || !char_stall) begin
        if (chars_to_send.size() > 0 && (calm || $urandom_range(99) >= 24)) begin
          char_item  <= chars_to_send.pop_front();
          char_valid <= 1'b1;
        end else begin
          char_valid <= 1'b0;
        end
      end
    end
  end

  // Token receiver: stall at random outside the calm stretch
  always @(posedge clk) begin
    if (rst) begin
      token_stall <= 1'b0;
    end else begin
      token_stall <= !calm && ($urandom_range(99) < 24);
    end
  end

  // Token monitor: compare each accepted token with the oldest prediction
  always @(posedge clk) begin
    token_t want;
    if (!rst && token_valid && !token_stall) begin
      if (tokens_due.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: unexpected token kind=%0d num=%0d letter=%0h last=%0b", $realtime,
                   token.token_kind, token.number_value, token.letter_code, token.last_of_run);
        mismatches <= mismatches + 1;
      end else begin
        want = tokens_due.pop_front();
        if (token.token_kind !== want.token_kind || token.number_value !== want.number_value ||
            token.letter_code !== want.letter_code || token.last_of_run !== want.last_of_run) begin
          if (mismatches < 10) begin
            $display("%0t: token mismatch exp kind=%0d num=%0d letter=%0h last=%0b",
                     $realtime, want.token_kind, want.number_value, want.letter_code,
                     want.last_of_run);
            $display("%0t:                got kind=%0d num=%0d letter=%0h last=%0b",
                     $realtime, token.token_kind, token.number_value,
                     token.letter_code, token.last_of_run);
          end
          mismatches <= mismatches + 1;
        end
      end
    end
  end

  // Hold until every character is sent and every token has come back
  task automatic wait_drained();
    do @(negedge clk);
    while (chars_to_send.size() != 0 || char_valid || tokens_due.size() != 0);
  endtask

  initial begin
    // leading zeros, repeated abstraction, stray dot, letters and brackets
    queue_text("007(", 1'b0);
    queue_text("LLx.", 1'b0);
    queue_text(".", 1'b0);
    queue_text("Az)", 1'b0);
    // codes that give no token, then an abstraction left open at the end
    push_char(8'h00, 1'b0);
    push_char(8'hFF, 1'b0);
    queue_text("L", 1'b1);
    // a number past the saturation limit, flushed by the final character
    queue_text("9999999999", 1'b1);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // pause the sender until the directed tokens are all back
    wait_drained();
    @(negedge clk);
    while (chars_to_send.size() < 1375) queue_term();
    wait_drained();
    repeat (20) @(posedge clk);

    if (mismatches == 0 && tokens_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Run limit
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/ltt_pkg.sv
rtl/core/ltt_scan.sv
rtl/core/lambda_term_tokenizer.sv
verif/tb_lambda_term_tokenizer.sv
